[src/sicf_pkg.sv]
`default_nettype none

package sicf_pkg;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int TAP_W    = 29;
  localparam int COEF_W   = 24;
  localparam int IDX_W    = 5;
  localparam int DATA_W   = 24;

  // configuration port, room for up to 16 tap registers in all
  localparam int CFG_IDX_W = 4;
  localparam int TAP_CNT_W = 4;

  // digit-serial multiplier: one 4-bit coefficient digit per cycle
  localparam int DIGIT_W   = 4;
  localparam int DIGITS    = COEF_W / DIGIT_W;
  localparam int DIG_CNT_W = $clog2(DIGITS);
  localparam int PROD_W    = COEF_W + DATA_W;
  localparam int ACC_W     = PROD_W + 4;

  // sample enters the sum at Q.30, intermediate rounds at 22, output at 30
  localparam int X_SHIFT = 30;
  localparam int W_SHIFT = 22;
  localparam int Y_SHIFT = 30;

  localparam int DATA_MAX = 8388607;
  localparam int DATA_MIN = -8388608;
  localparam int OUT_MAX  = 32767;
  localparam int OUT_MIN  = -32768;

  localparam logic [TAP_W-1:0] FWD0_RESET = 29'd4194304;

  // defaults for the top level parameters
  localparam int DEF_DELAY_LENGTH  = 32;
  localparam int DEF_FEEDBACK_TAPS = 3;
  localparam int DEF_FORWARD_TAPS  = 4;

  typedef struct packed {
    logic                 is_fwd;
    logic [TAP_CNT_W-1:0] cnt;
  } tap_sel_t;

  typedef struct packed {
    logic load_x;
    logic clear_acc;
    logic load_coef;
    logic step;
    logic first;
    logic acc_add;
    logic acc_sub;
  } mac_ctrl_t;

endpackage

`default_nettype wire

[src/sicf_tap_regs.sv]
`default_nettype none

module sicf_tap_regs #(
  parameter int FEEDBACK_TAPS = sicf_pkg::DEF_FEEDBACK_TAPS,
  parameter int FORWARD_TAPS  = sicf_pkg::DEF_FORWARD_TAPS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [sicf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sicf_pkg::TAP_W-1:0]     cfg_wdata,
  input  wire sicf_pkg::tap_sel_t             sel,
  output logic      [sicf_pkg::TAP_W-1:0]     tap
);
  import sicf_pkg::*;

  logic [TAP_W-1:0] fb_tap_r  [FEEDBACK_TAPS];
  logic [TAP_W-1:0] fwd_tap_r [FORWARD_TAPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FEEDBACK_TAPS; i++) fb_tap_r[i] <= '0;
      for (int j = 0; j < FORWARD_TAPS; j++) fwd_tap_r[j] <= (j == 0) ? FWD0_RESET : '0;
    end else if (cfg_we) begin
      for (int i = 0; i < FEEDBACK_TAPS; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) fb_tap_r[i] <= cfg_wdata;
      end
      for (int j = 0; j < FORWARD_TAPS; j++) begin
        if (cfg_index == CFG_IDX_W'(FEEDBACK_TAPS + j)) fwd_tap_r[j] <= cfg_wdata;
      end
    end
  end

  always_comb begin
    tap = '0;
    for (int i = 0; i < FEEDBACK_TAPS; i++) begin
      if (!sel.is_fwd && sel.cnt == TAP_CNT_W'(i)) tap = fb_tap_r[i];
    end
    for (int j = 0; j < FORWARD_TAPS; j++) begin
      if (sel.is_fwd && sel.cnt == TAP_CNT_W'(j)) tap = fwd_tap_r[j];
    end
  end

endmodule

`default_nettype wire

[src/sicf_delay_mem.sv]
`default_nettype none

module sicf_delay_mem #(
  parameter int DELAY_LENGTH = sicf_pkg::DEF_DELAY_LENGTH,
  localparam int ADDR_W      = $clog2(DELAY_LENGTH)
) (
  input  wire logic                        clk,
  input  wire logic                        rd_en,
  input  wire logic [ADDR_W-1:0]           base,
  input  wire logic [sicf_pkg::IDX_W-1:0]  rd_idx,
  output logic signed [sicf_pkg::DATA_W-1:0] rd_data,
  input  wire logic                        wr_en,
  input  wire logic [ADDR_W-1:0]           wr_addr,
  input  wire logic signed [sicf_pkg::DATA_W-1:0] wr_data
);
  import sicf_pkg::*;

  localparam int IDX_N = 2 ** IDX_W;

  logic signed [DATA_W-1:0] mem_r [DELAY_LENGTH];
  logic signed [DATA_W-1:0] rd_data_r;
  logic [ADDR_W-1:0]        idx_mod [IDX_N];
  logic [ADDR_W:0]          slot_sum;
  logic [ADDR_W-1:0]        slot;

  // delay index folded into the line length
  for (genvar g = 0; g < IDX_N; g++) begin : g_mod
    assign idx_mod[g] = ADDR_W'(g % DELAY_LENGTH);
  end

  always_comb begin
    slot_sum = {1'b0, base} + {1'b0, idx_mod[rd_idx]};
    if (slot_sum >= (ADDR_W + 1)'(DELAY_LENGTH)) begin
      slot_sum = slot_sum - (ADDR_W + 1)'(DELAY_LENGTH);
    end
    slot = slot_sum[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem_r[slot];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[src/sicf_mac.sv]
`default_nettype none

module sicf_mac (
  input  wire logic                               clk,
  input  wire sicf_pkg::mac_ctrl_t                ctrl,
  input  wire logic signed [sicf_pkg::SAMPLE_W-1:0] x,
  input  wire logic        [sicf_pkg::COEF_W-1:0]   coef,
  input  wire logic signed [sicf_pkg::DATA_W-1:0]   data,
  output logic signed      [sicf_pkg::DATA_W-1:0]   w0,
  output logic signed      [sicf_pkg::SAMPLE_W-1:0] y
);
  import sicf_pkg::*;

  localparam logic signed [ACC_W-1:0] HALF_W  = ACC_W'(1) <<< (W_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] HALF_Y  = ACC_W'(1) <<< (Y_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] W_HI    = ACC_W'(DATA_MAX);
  localparam logic signed [ACC_W-1:0] W_LO    = ACC_W'(DATA_MIN);
  localparam logic signed [ACC_W-1:0] Y_HI    = ACC_W'(OUT_MAX);
  localparam logic signed [ACC_W-1:0] Y_LO    = ACC_W'(OUT_MIN);

  logic        [COEF_W-1:0]       coef_sr_r;
  logic signed [PROD_W-1:0]       p_r;
  logic signed [ACC_W-1:0]        acc_r;
  logic signed [DIGIT_W:0]        dig_s;
  logic signed [DIGIT_W+DATA_W:0] dig_prod;
  logic signed [PROD_W-1:0]       p_nxt;
  logic signed [ACC_W-1:0]        rnd_w;
  logic signed [ACC_W-1:0]        rnd_y;

  // msb digit first; only the top digit carries the sign
  always_comb begin
    dig_s = ctrl.first ? {coef_sr_r[COEF_W-1], coef_sr_r[COEF_W-1 -: DIGIT_W]}
                       : {1'b0, coef_sr_r[COEF_W-1 -: DIGIT_W]};
    dig_prod = dig_s * data;
    p_nxt = (ctrl.first ? PROD_W'(0) : (p_r <<< DIGIT_W)) + PROD_W'(dig_prod);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_coef) begin
      coef_sr_r <= coef;
    end else if (ctrl.step) begin
      coef_sr_r <= coef_sr_r << DIGIT_W;
      p_r <= p_nxt;
    end

    if (ctrl.load_x) begin
      acc_r <= ACC_W'(x) <<< X_SHIFT;
    end else if (ctrl.clear_acc) begin
      acc_r <= '0;
    end else if (ctrl.acc_add) begin
      acc_r <= acc_r + ACC_W'(p_r);
    end else if (ctrl.acc_sub) begin
      acc_r <= acc_r - ACC_W'(p_r);
    end
  end

  // round half up, then saturate
  always_comb begin
    rnd_w = (acc_r + HALF_W) >>> W_SHIFT;
    if (rnd_w > W_HI)      w0 = W_HI[DATA_W-1:0];
    else if (rnd_w < W_LO) w0 = W_LO[DATA_W-1:0];
    else                   w0 = rnd_w[DATA_W-1:0];

    rnd_y = (acc_r + HALF_Y) >>> Y_SHIFT;
    if (rnd_y > Y_HI)      y = Y_HI[SAMPLE_W-1:0];
    else if (rnd_y < Y_LO) y = Y_LO[SAMPLE_W-1:0];
    else                   y = rnd_y[SAMPLE_W-1:0];
  end

endmodule

`default_nettype wire

[src/sparse_iir_circular_filter_core.sv]
`default_nettype none

// Sparse direct form II IIR filter on a circular delay line of DELAY_LENGTH
// Q16.8 words. Each tap register holds a 5-bit delay index (bits 28..24) and a
// signed Q2.22 coefficient (bits 23..0); feedback taps come first in the
// register map, then the feed-forward taps. All taps go through one shared
// multiplier that takes the coefficient 4 bits per cycle. Each tap is a read,
// six digit steps and an accumulate; the write-back follows the feedback
// taps, the output follows the forward taps, and then the core returns to
// idle. in_stall is high while a word is being worked on; a finished result
// waits in the output register while the next word is taken. After reset
// the delay line is cleared one entry a cycle, with in_stall held high; tap
// registers can be written meanwhile.
module sparse_iir_circular_filter_core #(
  parameter int DELAY_LENGTH  = sicf_pkg::DEF_DELAY_LENGTH,
  parameter int FEEDBACK_TAPS = sicf_pkg::DEF_FEEDBACK_TAPS,
  parameter int FORWARD_TAPS  = sicf_pkg::DEF_FORWARD_TAPS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [sicf_pkg::SAMPLE_W-1:0] in_sample_in,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed      [sicf_pkg::SAMPLE_W-1:0] out_sample_out,
  input  wire logic                                 cfg_we,
  input  wire logic        [sicf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [sicf_pkg::TAP_W-1:0]    cfg_wdata
);
  import sicf_pkg::*;

  localparam int ADDR_W = $clog2(DELAY_LENGTH);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_FETCH, S_MUL, S_ACC, S_WRITE, S_OUT
  } state_t;

  state_t                   state_r;
  logic [ADDR_W-1:0]        base_r;
  logic [ADDR_W-1:0]        clr_cnt_r;
  logic                     is_fwd_r;
  logic [TAP_CNT_W-1:0]     tap_cnt_r;
  logic [DIG_CNT_W-1:0]     dig_cnt_r;
  logic                     out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;

  tap_sel_t                 sel;
  mac_ctrl_t                mac_ctrl;
  logic [TAP_W-1:0]         tap;
  logic signed [DATA_W-1:0] rd_data;
  logic signed [DATA_W-1:0] w0;
  logic signed [SAMPLE_W-1:0] y;
  logic                     rd_en;
  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic signed [DATA_W-1:0] wr_data;

  assign sel.is_fwd = is_fwd_r;
  assign sel.cnt    = tap_cnt_r;

  sicf_tap_regs #(
    .FEEDBACK_TAPS(FEEDBACK_TAPS),
    .FORWARD_TAPS (FORWARD_TAPS)
  ) u_taps (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .sel      (sel),
    .tap      (tap)
  );

  sicf_delay_mem #(
    .DELAY_LENGTH(DELAY_LENGTH)
  ) u_mem (
    .clk    (clk),
    .rd_en  (rd_en),
    .base   (base_r),
    .rd_idx (tap[TAP_W-1 -: IDX_W]),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  sicf_mac u_mac (
    .clk (clk),
    .ctrl(mac_ctrl),
    .x   (in_sample_in),
    .coef(tap[COEF_W-1:0]),
    .data(rd_data),
    .w0  (w0),
    .y   (y)
  );

  always_comb begin
    mac_ctrl = '0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = base_r;
    wr_data  = w0;
    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = '0;
      end
      S_IDLE:  mac_ctrl.load_x = in_valid;
      S_FETCH: begin
        rd_en              = 1'b1;
        mac_ctrl.load_coef = 1'b1;
      end
      S_MUL: begin
        mac_ctrl.step  = 1'b1;
        mac_ctrl.first = (dig_cnt_r == '0);
      end
      S_ACC: begin
        mac_ctrl.acc_add = is_fwd_r;
        mac_ctrl.acc_sub = !is_fwd_r;
      end
      S_WRITE: begin
        // new intermediate goes to slot 0, then the forward sum starts over
        wr_en              = 1'b1;
        mac_ctrl.clear_acc = 1'b1;
      end
      S_OUT:   ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      base_r       <= '0;
      clr_cnt_r    <= '0;
      is_fwd_r     <= 1'b0;
      tap_cnt_r    <= '0;
      dig_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
      out_sample_r <= '0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == ADDR_W'(DELAY_LENGTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            is_fwd_r  <= 1'b0;
            tap_cnt_r <= '0;
            state_r   <= S_FETCH;
          end
        end
        S_FETCH: begin
          dig_cnt_r <= '0;
          state_r   <= S_MUL;
        end
        S_MUL: begin
          dig_cnt_r <= dig_cnt_r + 1'b1;
          if (dig_cnt_r == DIG_CNT_W'(DIGITS - 1)) state_r <= S_ACC;
        end
        S_ACC: begin
          tap_cnt_r <= tap_cnt_r + 1'b1;
          if (!is_fwd_r && tap_cnt_r == TAP_CNT_W'(FEEDBACK_TAPS - 1)) begin
            state_r <= S_WRITE;
          end else if (is_fwd_r && tap_cnt_r == TAP_CNT_W'(FORWARD_TAPS - 1)) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_FETCH;
          end
        end
        S_WRITE: begin
          is_fwd_r  <= 1'b1;
          tap_cnt_r <= '0;
          state_r   <= S_FETCH;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_sample_r <= y;
            base_r       <= (base_r == '0) ? ADDR_W'(DELAY_LENGTH - 1) : base_r - 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

endmodule

`default_nettype wire
